// ===== sv/fbp_pkg.sv =====
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared types and constants of the face box post-processing block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbp_pkg;

    localparam int unsigned DIM_W     = 13;
    localparam int unsigned TAG_W     = 16;
    localparam int unsigned EXP_W     = 10;
    localparam int unsigned FRAC_W    = 17;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [FRAC_W-1:0] Q16_ONE = 17'd65536;

    // floor(13*w/10) as (w * RECIP_13_10) >> NH_SHIFT, exact for w below 20164.
    localparam logic [19:0] RECIP_13_10 = 20'd681577;
    localparam int unsigned NH_SHIFT    = 19;
    // floor(2*h/3) as (h * RECIP_2_3) >> NW_SHIFT, exact for h below 65536.
    localparam logic [16:0] RECIP_2_3   = 17'd87382;
    localparam int unsigned NW_SHIFT    = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE        = 3'd0,
        CFG_BOX_EXPANSION = 3'd1,
        CFG_IMAGE_WIDTH   = 3'd2,
        CFG_IMAGE_HEIGHT  = 3'd3,
        CFG_MIN_SIZE      = 3'd4,
        CFG_MAX_SIZE      = 3'd5,
        CFG_MAX_CENTER    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic        [13:0] w;
        logic        [13:0] h;
    } t_box;

endpackage

`default_nettype wire

// ===== sv/fbp_in_if.sv =====
// ----------------------------------------------------------------------------
// fbp_in_if
// Valid/ready channel that carries one detected box per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbp_in_if import fbp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DIM_W-1:0] box_left;
    logic signed [DIM_W-1:0] box_top;
    logic        [DIM_W-1:0] box_width;
    logic        [DIM_W-1:0] box_height;
    logic        [TAG_W-1:0] box_tag;

    modport source (output valid, box_left, box_top, box_width, box_height, box_tag,
                    input ready);
    modport sink   (input valid, box_left, box_top, box_width, box_height, box_tag,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/fbp_out_if.sv =====
// ----------------------------------------------------------------------------
// fbp_out_if
// Valid/ready channel that carries one processed box per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbp_out_if import fbp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DIM_W-1:0] out_left;
    logic signed [DIM_W-1:0] out_top;
    logic        [DIM_W-1:0] out_width;
    logic        [DIM_W-1:0] out_height;
    logic        [TAG_W-1:0] out_tag;

    modport source (output valid, out_left, out_top, out_width, out_height, out_tag,
                    input ready);
    modport sink   (input valid, out_left, out_top, out_width, out_height, out_tag,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/fbp_clip.sv =====
// ----------------------------------------------------------------------------
// fbp_clip
// Intersects a box with the image rectangle; an empty result is 0,0,0,0.
// ----------------------------------------------------------------------------
`default_nettype none

module fbp_clip import fbp_pkg::*; (
    input  t_box             i_box,
    input  logic [DIM_W-1:0] i_img_w,
    input  logic [DIM_W-1:0] i_img_h,
    output t_box             o_box
);

    logic signed [16:0] x0, y0, x1, y1, x1_raw, y1_raw, iw, ih, dx, dy;
    logic               empty;

    always_comb begin
        iw     = {4'b0000, i_img_w};
        ih     = {4'b0000, i_img_h};
        x1_raw = {i_box.l[15], i_box.l} + {3'b000, i_box.w};
        y1_raw = {i_box.t[15], i_box.t} + {3'b000, i_box.h};
        x0     = i_box.l[15] ? 17'sd0 : {1'b0, i_box.l};
        y0     = i_box.t[15] ? 17'sd0 : {1'b0, i_box.t};
        x1     = (x1_raw > iw) ? iw : x1_raw;
        y1     = (y1_raw > ih) ? ih : y1_raw;
        dx     = x1 - x0;
        dy     = y1 - y0;
        empty  = (x1 <= x0) || (y1 <= y0);
        if (empty) begin
            o_box = '0;
        end else begin
            o_box.l = x0[15:0];
            o_box.t = y0[15:0];
            o_box.w = dx[13:0];
            o_box.h = dy[13:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/face_box_postprocess.sv =====
// ----------------------------------------------------------------------------
// face_box_postprocess
// Grows, reshapes, clips and filters detected face boxes.
// ----------------------------------------------------------------------------
// Boxes enter on i_box and leave on o_box, both valid/ready channels; a beat
// moves at a clock edge where valid and ready are both high. Each box gives
// at most one result beat; a box that fails the size or center-row limits is
// dropped, and the tag travels with the box unchanged.
// The block is a five-register pipeline: input register, expanded and
// clipped box, aspect products, reshaped and clipped box, result register.
// A box moves through these stages in order, and one box can be accepted
// in every cycle unless the receiver stalls and every stage is full.
// When the receiver stalls, the result register holds and the stages behind
// it fill up; i_box.ready stays high while any stage can still move, so up
// to five boxes are held before the input stalls.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data; the
// user must write them only while no box is in flight, which the block does
// not enforce. Reset clears the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module face_box_postprocess import fbp_pkg::*; #(
    parameter int unsigned MAX_IMAGE_DIM = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    fbp_in_if.sink                    i_box,
    fbp_out_if.source                 o_box,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FRAC_W-1:0]    i_cfg_data
);

    localparam int unsigned DIM_ALL_ONES = (1 << DIM_W) - 1;
    localparam int unsigned DIM_CAP_INT  =
        (MAX_IMAGE_DIM > DIM_ALL_ONES) ? DIM_ALL_ONES : MAX_IMAGE_DIM;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_CAP_INT);

    // Configuration and derived limits.
    logic              r_enable;
    logic [EXP_W-1:0]  r_box_expansion;
    logic [DIM_W-1:0]  r_image_width, r_image_height;
    logic [FRAC_W-1:0] r_min_size_fraction, r_max_size_fraction, r_max_center_fraction;
    logic [DIM_W-1:0]  r_iw_cap, r_ih_cap, r_min_side, r_max_side, r_max_y;
    logic [DIM_W-1:0]  n_iw_cap, n_ih_cap, n_min_side, n_max_side, n_max_y, min_dim;
    logic [FRAC_W-1:0] min_frac, max_frac, ctr_frac;
    logic [29:0]       min_prod, max_prod, ctr_prod;

    // Pipeline.
    logic             r_va, r_vb, r_vc, r_vd, r_vo;
    logic             en_a, en_b, en_c, en_d, en_o;
    t_box             r_a_box, r_b_box, r_c_box, r_d_box;
    logic [TAG_W-1:0] r_a_tag, r_b_tag, r_c_tag, r_d_tag, r_o_tag;
    logic             r_c_wide, r_c_tall;
    logic [13:0]      r_c_nh, r_c_nw;
    logic [DIM_W-1:0] r_o_left, r_o_top, r_o_width, r_o_height;

    t_box               exp_box, clip1_box, n_b_box, adj_box, clip2_box, n_d_box;
    logic [16:0]        h5, w6, w9;
    logic               n_c_wide, n_c_tall;
    logic [33:0]        nh_prod;
    logic [30:0]        nw_prod;
    logic signed [15:0] diff, half;
    logic [14:0]        center_row;
    logic               keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable              <= 1'b1;
            r_box_expansion       <= '0;
            r_image_width         <= 13'd640;
            r_image_height        <= 13'd480;
            r_min_size_fraction   <= 17'd3277;
            r_max_size_fraction   <= Q16_ONE;
            r_max_center_fraction <= Q16_ONE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:        r_enable              <= i_cfg_data[0];
                CFG_BOX_EXPANSION: r_box_expansion       <= i_cfg_data[EXP_W-1:0];
                CFG_IMAGE_WIDTH:   r_image_width         <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height        <= i_cfg_data[DIM_W-1:0];
                CFG_MIN_SIZE:      r_min_size_fraction   <= i_cfg_data;
                CFG_MAX_SIZE:      r_max_size_fraction   <= i_cfg_data;
                CFG_MAX_CENTER:    r_max_center_fraction <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_iw_cap   = (r_image_width > DIM_CAP) ? DIM_CAP : r_image_width;
        n_ih_cap   = (r_image_height > DIM_CAP) ? DIM_CAP : r_image_height;
        min_frac   = (r_min_size_fraction > Q16_ONE) ? Q16_ONE : r_min_size_fraction;
        max_frac   = (r_max_size_fraction > Q16_ONE) ? Q16_ONE : r_max_size_fraction;
        ctr_frac   = (r_max_center_fraction > Q16_ONE) ? Q16_ONE : r_max_center_fraction;
        min_dim    = (r_iw_cap < r_ih_cap) ? r_iw_cap : r_ih_cap;
        min_prod   = min_dim * min_frac;
        max_prod   = min_dim * max_frac;
        ctr_prod   = r_ih_cap * ctr_frac;
        n_min_side = min_prod[28:16];
        n_max_side = max_prod[28:16];
        n_max_y    = ctr_prod[28:16];
    end

    always_ff @(posedge i_clk) begin
        r_iw_cap   <= n_iw_cap;
        r_ih_cap   <= n_ih_cap;
        r_min_side <= n_min_side;
        r_max_side <= n_max_side;
        r_max_y    <= n_max_y;
    end

    // A stage loads when it is empty or the stage after it loads.
    assign en_o        = !r_vo || o_box.ready;
    assign en_d        = !r_vd || en_o;
    assign en_c        = !r_vc || en_d;
    assign en_b        = !r_vb || en_c;
    assign en_a        = !r_va || en_b;
    assign i_box.ready = en_a;

    // Expansion and first clip.
    always_comb begin
        exp_box.l = r_a_box.l - $signed({6'b000000, r_box_expansion});
        exp_box.t = r_a_box.t - $signed({6'b000000, r_box_expansion});
        exp_box.w = r_a_box.w + {3'b000, r_box_expansion, 1'b0};
        exp_box.h = r_a_box.h + {3'b000, r_box_expansion, 1'b0};
        n_b_box   = r_enable ? clip1_box : r_a_box;
    end

    fbp_clip u_clip_exp (
        .i_box   (exp_box),
        .i_img_w (r_iw_cap),
        .i_img_h (r_ih_cap),
        .o_box   (clip1_box)
    );

    // Aspect tests and the reshaped side lengths.
    always_comb begin
        h5       = {1'b0, r_b_box.h, 2'b00} + {3'b000, r_b_box.h};
        w6       = {1'b0, r_b_box.w, 2'b00} + {2'b00, r_b_box.w, 1'b0};
        w9       = {r_b_box.w, 3'b000} + {3'b000, r_b_box.w};
        n_c_wide = r_enable && (h5 < w6);
        n_c_tall = r_enable && !(h5 < w6) && (h5 > w9);
        nh_prod  = r_b_box.w * RECIP_13_10;
        nw_prod  = r_b_box.h * RECIP_2_3;
    end

    // Recentering and second clip.
    always_comb begin
        diff    = r_c_wide ? ($signed({2'b00, r_c_nh}) - $signed({2'b00, r_c_box.h}))
                           : ($signed({2'b00, r_c_nw}) - $signed({2'b00, r_c_box.w}));
        half    = (diff + $signed({15'd0, diff[15]})) >>> 1;
        adj_box = r_c_box;
        if (r_c_wide) begin
            adj_box.t = r_c_box.t - half;
            adj_box.h = r_c_nh;
        end else if (r_c_tall) begin
            adj_box.l = r_c_box.l - half;
            adj_box.w = r_c_nw;
        end
        n_d_box = r_enable ? clip2_box : r_c_box;
    end

    fbp_clip u_clip_adj (
        .i_box   (adj_box),
        .i_img_w (r_iw_cap),
        .i_img_h (r_ih_cap),
        .o_box   (clip2_box)
    );

    // Size and center-row limits.
    always_comb begin
        center_row = {1'b0, r_d_box.t[13:0]} + {2'b00, r_d_box.h[13:1]};
        keep = !r_enable ||
               !((r_d_box.w < {1'b0, r_min_side}) || (r_d_box.h < {1'b0, r_min_side}) ||
                 (r_d_box.w > {1'b0, r_max_side}) || (r_d_box.h > {1'b0, r_max_side}) ||
                 (center_row > {2'b00, r_max_y}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_a) r_va <= i_box.valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (en_d) r_vd <= r_vc;
            if (en_o) r_vo <= r_vd && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_box.l <= {{3{i_box.box_left[DIM_W-1]}}, i_box.box_left};
            r_a_box.t <= {{3{i_box.box_top[DIM_W-1]}}, i_box.box_top};
            r_a_box.w <= {1'b0, i_box.box_width};
            r_a_box.h <= {1'b0, i_box.box_height};
            r_a_tag   <= i_box.box_tag;
        end
        if (en_b) begin
            r_b_box <= n_b_box;
            r_b_tag <= r_a_tag;
        end
        if (en_c) begin
            r_c_box  <= r_b_box;
            r_c_tag  <= r_b_tag;
            r_c_wide <= n_c_wide;
            r_c_tall <= n_c_tall;
            r_c_nh   <= nh_prod[NH_SHIFT+13:NH_SHIFT];
            r_c_nw   <= nw_prod[NW_SHIFT+13:NW_SHIFT];
        end
        if (en_d) begin
            r_d_box <= n_d_box;
            r_d_tag <= r_c_tag;
        end
        if (en_o) begin
            r_o_left   <= r_d_box.l[DIM_W-1:0];
            r_o_top    <= r_d_box.t[DIM_W-1:0];
            r_o_width  <= r_d_box.w[DIM_W-1:0];
            r_o_height <= r_d_box.h[DIM_W-1:0];
            r_o_tag    <= r_d_tag;
        end
    end

    assign o_box.valid      = r_vo;
    assign o_box.out_left   = $signed(r_o_left);
    assign o_box.out_top    = $signed(r_o_top);
    assign o_box.out_width  = r_o_width;
    assign o_box.out_height = r_o_height;
    assign o_box.out_tag    = r_o_tag;

endmodule

`default_nettype wire

// ===== sv/fbp_checker.sv =====
// ----------------------------------------------------------------------------
// fbp_checker
// Port-level checks of the face box post-processing block.
// ----------------------------------------------------------------------------
`default_nettype none

module fbp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [67:0] i_out_data
);

    // The output register is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result beat shown right after reset");

    // When the result register can move, nothing behind it may stall the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while the output side was free");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("result beat changed while stalled");

    a_valid_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_in_valid, i_out_valid}))
        else $error("valid flag unknown outside reset");

endmodule

bind face_box_postprocess fbp_checker u_fbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_box.valid),
    .i_in_ready  (i_box.ready),
    .i_out_valid (o_box.valid),
    .i_out_ready (o_box.ready),
    .i_out_data  ({o_box.out_left, o_box.out_top, o_box.out_width,
                   o_box.out_height, o_box.out_tag})
);

`default_nettype wire
